@@ hdl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int BLK_W   = 20;  // block numbers
  localparam int CNT_W   = 17;  // free counter
  localparam int CS_W    = 16;  // cylinder size and rotational space
  localparam int POS_W   = 23;  // signed bit positions and region bounds
  localparam int CFG_W   = 2;   // register index
  localparam int DVD_W   = 20;  // divider dividend
  localparam int DSR_W   = 16;  // divider divisor

  localparam int MAP_BITS_DEF  = 65536;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [CNT_W-1:0] CNT_MAX     = 17'h1FFFF;
  localparam logic [CS_W-1:0]  DEF_CYL     = 16'd40;
  localparam logic [CS_W-1:0]  DEF_SPACE   = 16'd4;
  localparam logic [BLK_W-1:0] FS_SIZE_RST = 20'd65536;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [CFG_W-1:0] CFG_FIRST_DATA = 2'd0;
  localparam logic [CFG_W-1:0] CFG_FS_SIZE    = 2'd1;
  localparam logic [CFG_W-1:0] CFG_CYL_SIZE   = 2'd2;
  localparam logic [CFG_W-1:0] CFG_ROT_SPACE  = 2'd3;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

endpackage

@@ hdl/bba_map_ram.sv @@
// ----------------------------------------------------------------------------
// bba_map_ram
// Free bitmap storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_map_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bba_div.sv @@
// ----------------------------------------------------------------------------
// bba_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bba_div
  import bba_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CW = $clog2(DVD_W);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DSR_W-1:0] rem_q;
  logic [DSR_W-1:0] dsr_q;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= req_i.dividend;
        rem_q  <= '0;
        dsr_q  <= req_i.divisor;
      end else if (busy_q) begin
        quo_q <= {quo_q[DVD_W-2:0], ge};
        rem_q <= ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

@@ hdl/bitmap_block_allocator_locality_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_locality_core
// Free-block bitmap allocator with a cylinder locality hint.
// ----------------------------------------------------------------------------
// The block takes one request at a time. After reset it sweeps the bitmap
// memory to zero with in_ready_o low; configuration writes are taken during
// the sweep. WORD_BITS must be a power of two (the block does not check it),
// so a bit index splits into word and offset by its bit fields. A free request
// in range reads the word, writes it back and loads the output register; the
// next request can be taken in the cycle after the load. A free out of range
// goes straight to the load. An allocate request with the hint at or above the
// first data block first runs the bit-serial divider for the cylinder base,
// captures the quotient, multiplies back and forms the region bounds. Each
// region (hint cylinder, next two cylinders, whole map; only the last without
// a hint) is started, or skipped when empty, and scanned word by word, a read
// and a check per word, as the single memory port has a registered read. The
// found bit is cleared by a final read and write-back, then the result is
// loaded. Worst case is about two full-map scans, as the hint cylinder and the
// next two do not overlap. A finished result sits in an output register, so
// the next request is accepted while it waits; a second finished result holds
// the block until the first is taken.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_locality_core
  import bba_pkg::*;
#(
  parameter int MAP_BITS  = MAP_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_idx_i,
  input  logic [BLK_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  logic [BLK_W-1:0] prev_block_i,
  input  logic [BLK_W-1:0] block_number_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [BLK_W-1:0] result_block_o,
  output logic [1:0]       status_o,
  output logic [CNT_W-1:0] free_count_o
);

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int KW        = $clog2(WORD_BITS);
  localparam pos_t WB      = pos_t'(WORD_BITS);
  localparam pos_t PMAX    = pos_t'(MAP_BITS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CDIV, S_MUL, S_BOUNDS, S_RSTART,
    S_READ, S_CHECK, S_FREAD, S_FWRITE, S_DONE
  } state_e;

  typedef enum logic [1:0] {REG_CYL, REG_NEAR, REG_ALL} region_e;

  state_e  state_q;
  region_e region_q;

  // configuration
  logic [BLK_W-1:0] isz_q, fsz_q;
  logic [CS_W-1:0]  cyl_q, rot_q;

  // request and search context
  logic             op_set_q;
  logic [BLK_W-1:0] prev_q;
  logic [DVD_W-1:0] quo_q;
  logic [BLK_W-1:0] base_q;
  pos_t             lo_q, hi_q, t_q, lo2_q, hi2_q;
  logic [AW-1:0]    w_q, fw_q, clr_q;
  pos_t             wbase_q, fpos_q;
  logic [KW-1:0]    fbit_q;
  logic             first_q;
  logic [CNT_W-1:0] cnt_q;
  logic [BLK_W-1:0] res_q;
  logic [1:0]       sts_q;

  // output register
  logic             out_valid_q;
  logic [BLK_W-1:0] out_blk_q;
  logic [1:0]       out_sts_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata, bit_mask;

  logic             accept, bad, hint, r_empty, advance;
  logic [CS_W-1:0]  cs_eff, sp_eff;
  logic [BLK_W:0]   bn_rel;
  pos_t             lo_c, hi_c, off_lo, off_hi, off_t;
  logic [WORD_BITS-1:0] vmask, pmask;
  logic [KW-1:0]    v_idx, p_idx;
  logic             last_word;
  logic [BLK_W-1:0] base_c, cyl_c, end_c;
  logic [BLK_W:0]   cyl_s;
  logic [BLK_W+1:0] end_s;

  function automatic logic [KW-1:0] lowest(input logic [WORD_BITS-1:0] v);
    logic [KW-1:0] idx;
    idx = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (v[k]) idx = KW'(k);
    end
    return idx;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // Zero cylinder size falls back to the classic geometry.
  assign cs_eff = (cyl_q == '0) ? DEF_CYL : cyl_q;
  assign sp_eff = (cyl_q == '0) ? DEF_SPACE : rot_q;

  assign bn_rel = {1'b0, block_number_i} - {1'b0, isz_q};
  assign bad    = (block_number_i < isz_q) || (block_number_i >= fsz_q) ||
                  (bn_rel >= (BLK_W+1)'(MAP_BITS));
  assign hint   = prev_block_i >= isz_q;

  // Region start: clip to the map.
  assign lo_c    = (lo_q < 0) ? '0 : lo_q;
  assign hi_c    = (hi_q > PMAX) ? PMAX : hi_q;
  assign r_empty = hi_c <= lo_c;

  // Cylinder bounds from the divided and multiplied base.
  assign base_c = (base_q < isz_q) ? isz_q : base_q;
  assign cyl_s  = {1'b0, base_c} + {{(BLK_W+1-CS_W){1'b0}}, cs_eff};
  assign end_s  = {2'b0, base_c} + {{(BLK_W+2-CS_W){1'b0}}, cs_eff}
                + {{(BLK_W+1-CS_W){1'b0}}, cs_eff, 1'b0};
  assign cyl_c  = (cyl_s > {1'b0, fsz_q}) ? fsz_q : cyl_s[BLK_W-1:0];
  assign end_c  = (end_s > {2'b0, fsz_q}) ? fsz_q : end_s[BLK_W-1:0];

  // Word check: free bits inside the region, and those past the preferred point.
  assign off_lo = lo_q - wbase_q;
  assign off_hi = hi_q - wbase_q;
  assign off_t  = t_q - wbase_q;

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      vmask[k] = ram_rdata[k] && (pos_t'(k) >= off_lo) && (pos_t'(k) < off_hi);
      pmask[k] = vmask[k] && (pos_t'(k) >= off_t);
    end
  end

  assign v_idx     = lowest(vmask);
  assign p_idx     = lowest(pmask);
  assign last_word = (wbase_q + WB) >= hi_q;

  assign advance = ((state_q == S_RSTART) && r_empty) ||
                   ((state_q == S_CHECK) && (pmask == '0) && last_word &&
                    !first_q && (vmask == '0));

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // The divider only splits the hint into cylinder number and offset.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = prev_block_i;
    div_req.divisor  = cs_eff;
    case (state_q)
      S_IDLE: begin
        if (accept && command_i == CMD_ALLOC && hint) begin
          div_req.start = 1'b1;
        end
      end
      default: ;
    endcase
  end

  bba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << fbit_q;
  assign ram_raddr = (state_q == S_FREAD) ? fw_q : w_q;
  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_FWRITE);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : fw_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 :
                     op_set_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);

  bba_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW),
    .DW    (WORD_BITS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      region_q    <= REG_ALL;
      isz_q       <= '0;
      fsz_q       <= FS_SIZE_RST;
      cyl_q       <= DEF_CYL;
      rot_q       <= DEF_SPACE;
      op_set_q    <= 1'b0;
      prev_q      <= '0;
      quo_q       <= '0;
      base_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      t_q         <= '0;
      lo2_q       <= '0;
      hi2_q       <= '0;
      w_q         <= '0;
      fw_q        <= '0;
      clr_q       <= '0;
      wbase_q     <= '0;
      fpos_q      <= '0;
      fbit_q      <= '0;
      first_q     <= 1'b0;
      cnt_q       <= '0;
      res_q       <= '0;
      sts_q       <= ST_OK;
      out_valid_q <= 1'b0;
      out_blk_q   <= '0;
      out_sts_q   <= ST_OK;
      out_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIRST_DATA: isz_q <= cfg_data_i;
          CFG_FS_SIZE:    fsz_q <= cfg_data_i;
          CFG_CYL_SIZE:   cyl_q <= cfg_data_i[CS_W-1:0];
          CFG_ROT_SPACE:  rot_q <= cfg_data_i[CS_W-1:0];
          default: ;
        endcase
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(MAP_WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            first_q <= 1'b0;
            if (command_i == CMD_FREE) begin
              op_set_q <= 1'b1;
              if (bad) begin
                res_q   <= '0;
                sts_q   <= ST_BAD;
                state_q <= S_DONE;
              end else begin
                // Word and offset are plain bit fields of the index.
                fw_q    <= bn_rel[AW+KW-1:KW];
                fbit_q  <= bn_rel[KW-1:0];
                state_q <= S_FREAD;
              end
            end else begin
              op_set_q <= 1'b0;
              prev_q   <= prev_block_i;
              if (hint) begin
                state_q <= S_CDIV;
              end else begin
                region_q <= REG_ALL;
                lo_q     <= '0;
                hi_q     <= pos_t'(fsz_q) - pos_t'(isz_q);
                t_q      <= '0;
                state_q  <= S_RSTART;
              end
            end
          end
        end
        S_CDIV: begin
          if (div_rsp.done) begin
            quo_q   <= div_rsp.quotient;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // (prev / cs) * cs never exceeds prev, so it fits a block number.
          base_q  <= BLK_W'(quo_q * cs_eff);
          state_q <= S_BOUNDS;
        end
        S_BOUNDS: begin
          region_q <= REG_CYL;
          lo_q     <= pos_t'(base_c) - pos_t'(isz_q);
          hi_q     <= pos_t'(cyl_c) - pos_t'(isz_q);
          t_q      <= pos_t'(prev_q) - pos_t'(isz_q) + pos_t'(sp_eff);
          lo2_q    <= pos_t'(cyl_c) - pos_t'(isz_q);
          hi2_q    <= pos_t'(end_c) - pos_t'(isz_q);
          state_q  <= S_RSTART;
        end
        S_RSTART: begin
          if (!r_empty) begin
            lo_q    <= lo_c;
            hi_q    <= hi_c;
            w_q     <= lo_c[AW+KW-1:KW];
            wbase_q <= lo_c & ~pos_t'(WORD_BITS - 1);
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (pmask != '0) begin
            fw_q    <= w_q;
            fbit_q  <= p_idx;
            fpos_q  <= wbase_q + pos_t'(p_idx);
            state_q <= S_FREAD;
          end else begin
            // Remember the first free bit of the cylinder as a fallback.
            if (!first_q && vmask != '0) begin
              first_q <= 1'b1;
              fw_q    <= w_q;
              fbit_q  <= v_idx;
              fpos_q  <= wbase_q + pos_t'(v_idx);
            end
            if (last_word) begin
              if (first_q || vmask != '0) begin
                state_q <= S_FREAD;
              end
            end else begin
              w_q     <= w_q + 1'b1;
              wbase_q <= wbase_q + WB;
              state_q <= S_READ;
            end
          end
        end
        S_FREAD: begin
          state_q <= S_FWRITE;
        end
        S_FWRITE: begin
          sts_q <= ST_OK;
          if (op_set_q) begin
            res_q <= '0;
            if (cnt_q != CNT_MAX) cnt_q <= cnt_q + 1'b1;
          end else begin
            res_q <= BLK_W'(fpos_q + pos_t'(isz_q));
            if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Drop to the next region, or report full after the whole map.
      if (advance) begin
        if (region_q == REG_ALL) begin
          cnt_q   <= '0;
          res_q   <= '0;
          sts_q   <= ST_FULL;
          state_q <= S_DONE;
        end else if (region_q == REG_CYL) begin
          region_q <= REG_NEAR;
          lo_q     <= lo2_q;
          hi_q     <= hi2_q;
          t_q      <= '0;
          state_q  <= S_RSTART;
        end else begin
          region_q <= REG_ALL;
          lo_q     <= '0;
          hi_q     <= pos_t'(fsz_q) - pos_t'(isz_q);
          t_q      <= '0;
          state_q  <= S_RSTART;
        end
      end

      // Load a finished result, or drop the one just taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_blk_q   <= res_q;
        out_sts_q   <= sts_q;
        out_cnt_q   <= cnt_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_block_o = out_blk_q;
  assign status_o       = out_sts_q;
  assign free_count_o   = out_cnt_q;

  a_full_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> free_count_o == '0)
    else $error("full status with nonzero free count");

  a_fail_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_BAD) |->
    result_block_o == '0)
    else $error("failed request returned a block");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  a_no_ram_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ram_we)
    else $error("bitmap written while idle");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the locality-hinted free-block bitmap allocator.
// A bit-accurate predictor runs beside the core. Each accepted request updates
// its copy of the bitmap and the free counter and queues the expected
// response, and a monitor compares every response as it is accepted.
// ----------------------------------------------------------------------------
module tb;
  import bba_pkg::*;

  localparam int  MAP_N     = MAP_BITS_DEF;
  localparam int  WDOG_MAX  = 100000;  // worst case: about two full-map scans plus a long hold
  localparam int  TAIL_CYC  = 60;
  localparam int  RX_HOLD   = 400;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [1:0]       st;
    logic [CNT_W-1:0] cnt;
  } alloc_rsp_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_idx = '0;
  logic [BLK_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             cmd = CMD_ALLOC;
  logic [BLK_W-1:0] prev_blk = '0;
  logic [BLK_W-1:0] blk_num = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [BLK_W-1:0] res_blk;
  logic [1:0]       res_st;
  logic [CNT_W-1:0] res_cnt;

  // predictor state
  bit               free_bits [MAP_N];
  longint           free_cnt;
  longint           first_data, fs_blocks, cyl_blocks, rot_gap;
  alloc_rsp_t       expected_rsp_q [$];

  int               errors = 0;
  bit               idle_en = 1'b1;
  int               hold_reqs = 0;   // bumped by a test to ask for a long hold-off
  int               hold_seen = 0;
  int               rx_hold = 0;     // long receiver hold-off, counted down by the receiver
  int               idle_cyc = 0;

  bitmap_block_allocator_locality_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (cmd),
    .prev_block_i   (prev_blk),
    .block_number_i (blk_num),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_block_o (res_blk),
    .status_o       (res_st),
    .free_count_o   (res_cnt)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // First free bit in [lo, hi), preferring one at least space past pref.
  function automatic longint find_free(longint lo, longint hi, longint pref, longint space);
    longint first;
    first = -1;
    if (lo < 0) lo = 0;
    if (hi > MAP_N) hi = MAP_N;
    for (longint i = lo; i < hi; i++) begin
      if (!free_bits[i]) continue;
      if (first < 0) first = i;
      if (i - pref >= space) return i;
    end
    return first;
  endfunction

  function automatic alloc_rsp_t predict_request(logic c, longint prev, longint bn);
    alloc_rsp_t r;
    longint cs, sp, best, base, cyl_end, reg_end;
    r = '0;
    if (c == CMD_ALLOC) begin
      cs = cyl_blocks;
      sp = rot_gap;
      best = -1;
      // a zero cylinder size falls back to the classic geometry
      if (cs == 0) begin
        cs = DEF_CYL;
        sp = DEF_SPACE;
      end
      if (prev >= first_data) begin
        base = (prev / cs) * cs;
        if (base < first_data) base = first_data;
        cyl_end = base + cs;
        reg_end = base + 3 * cs;
        if (reg_end > fs_blocks) reg_end = fs_blocks;
        if (cyl_end > fs_blocks) cyl_end = fs_blocks;
        best = find_free(base - first_data, cyl_end - first_data, prev - first_data, sp);
        if (best < 0) best = find_free(cyl_end - first_data, reg_end - first_data, 0, 0);
      end
      if (best < 0) best = find_free(0, fs_blocks - first_data, 0, 0);
      if (best < 0) begin
        free_cnt = 0;
        r.st = ST_FULL;
      end else begin
        free_bits[best] = 1'b0;
        if (free_cnt > 0) free_cnt--;
        r.blk = BLK_W'(best + first_data);
      end
    end else begin
      if (bn < first_data || bn >= fs_blocks || bn - first_data >= MAP_N) begin
        r.st = ST_BAD;
      end else begin
        // a double free still counts
        free_bits[bn - first_data] = 1'b1;
        if (free_cnt < CNT_MAX) free_cnt++;
      end
    end
    r.cnt = CNT_W'(free_cnt);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver, configuration and drain
  // --------------------------------------------------------------------------
  // Call right after a rising edge; returns at the edge that takes the request.
  task automatic send_request(logic c, logic [BLK_W-1:0] prev, logic [BLK_W-1:0] bn);
    if (idle_en && ($urandom % 4 == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    prev_blk <= prev;
    blk_num  <= bn;
    do @(posedge clk); while (!in_ready);
    expected_rsp_q.push_back(predict_request(c, prev, bn));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  // The enable drops after each write, so it is low between writes.
  task automatic write_reg(logic [CFG_W-1:0] idx, logic [BLK_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_FIRST_DATA: first_data = val;
      CFG_FS_SIZE:    fs_blocks  = val;
      CFG_CYL_SIZE:   cyl_blocks = val[CS_W-1:0];
      CFG_ROT_SPACE:  rot_gap    = val[CS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(longint fd, longint fs, longint cs, longint rs);
    write_reg(CFG_FIRST_DATA, BLK_W'(fd));
    write_reg(CFG_FS_SIZE, BLK_W'(fs));
    write_reg(CFG_CYL_SIZE, BLK_W'(cs));
    write_reg(CFG_ROT_SPACE, BLK_W'(rs));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_defaults;
    // empty map: full, then fill the edges of the default range
    send_request(CMD_ALLOC, 20'd0, 20'd0);
    send_request(CMD_FREE, 20'd0, 20'd0);
    send_request(CMD_FREE, 20'd0, 20'd65535);
    send_request(CMD_FREE, 20'd0, 20'd65536);
    send_request(CMD_FREE, 20'hFFFFF, 20'hFFFFF);
    send_request(CMD_FREE, 20'd0, 20'd0);      // double free
    send_request(CMD_ALLOC, 20'd0, 20'd0);
    send_request(CMD_ALLOC, 20'd65535, 20'd0);
    send_request(CMD_ALLOC, 20'd0, 20'd0);
    drain();
  endtask

  task automatic test_locality;
    // zero cylinder size with a huge space: geometry falls back to 40/4
    set_geometry(100, 400, 0, 65535);
    for (int i = 0; i < 6; i++) send_request(CMD_FREE, 20'd0, BLK_W'(100 + 7 * i));
    send_request(CMD_FREE, 20'd0, 20'd99);      // below the data area
    send_request(CMD_FREE, 20'd0, 20'd400);     // at fs_size
    send_request(CMD_ALLOC, 20'd101, 20'd0);    // preferred bit past the space
    send_request(CMD_ALLOC, 20'd130, 20'd0);    // free bits on both sides of the hint
    send_request(CMD_ALLOC, 20'd50, 20'd0);     // hint below the data area
    send_request(CMD_ALLOC, 20'd380, 20'd0);    // next cylinders clipped by fs_size
    send_request(CMD_ALLOC, 20'hFFFFF, 20'd0);  // hint far past the end
    drain();
  endtask

  task automatic test_counter_floor;
    set_geometry(0, 200, 16, 2);
    send_request(CMD_FREE, 20'd0, 20'd150);
    send_request(CMD_FREE, 20'd0, 20'd10);
    drain();
    // hide block 150, exhaust the rest, then bring it back into range
    write_reg(CFG_FS_SIZE, 20'd100);
    send_request(CMD_ALLOC, 20'd10, 20'd0);
    send_request(CMD_ALLOC, 20'd10, 20'd0);
    drain();
    write_reg(CFG_FS_SIZE, 20'd200);
    send_request(CMD_ALLOC, 20'd140, 20'd0);
    send_request(CMD_ALLOC, 20'd140, 20'd0);
    drain();
  endtask

  task automatic test_extremes;
    // widest geometry: searches clip at the map limit
    set_geometry(0, 20'hFFFFF, 65535, 65535);
    send_request(CMD_FREE, 20'd0, BLK_W'(MAP_N - 1));
    send_request(CMD_FREE, 20'd0, BLK_W'(MAP_N));
    send_request(CMD_FREE, 20'd0, 20'd3);
    send_request(CMD_ALLOC, 20'd0, 20'd0);
    send_request(CMD_ALLOC, 20'hFFFFF, 20'd0);
    send_request(CMD_ALLOC, 20'd0, 20'd0);
    drain();
    set_geometry(20'hFFFFF, 20'hFFFFF, 1, 0);
    send_request(CMD_FREE, 20'd0, 20'hFFFFF);
    send_request(CMD_ALLOC, 20'hFFFFF, 20'd0);
    drain();
    set_geometry(0, 0, 1, 0);
    send_request(CMD_FREE, 20'd0, 20'd0);
    send_request(CMD_ALLOC, 20'd0, 20'd0);
    drain();
  endtask

  task automatic random_request(longint span);
    int r;
    longint off;
    r = $urandom % 100;
    if (r < 50) begin
      off = first_data + $urandom_range(0, span - 1);
      send_request(CMD_FREE, BLK_W'($urandom), BLK_W'(off));
    end else if (r < 55) begin
      send_request(CMD_FREE, BLK_W'($urandom), BLK_W'($urandom));
    end else if (r < 93) begin
      off = first_data + $urandom_range(0, span + 80);
      send_request(CMD_ALLOC, BLK_W'(off), BLK_W'($urandom));
    end else begin
      send_request(CMD_ALLOC, BLK_W'($urandom), BLK_W'($urandom));
    end
  endtask

  task automatic test_random(int n);
    longint fd, span;
    fd   = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 20'hFFFFF - 700);
    span = $urandom_range(64, 600);
    set_geometry(fd, fd + span, ($urandom % 6 == 0) ? 0 : $urandom_range(1, 120),
                 $urandom_range(0, 60));
    for (int i = 0; i < n; i++) begin
      random_request(span);
      // pause the sender until everything is back, now and then
      if ($urandom % 97 == 0) drain();
    end
    drain();
  endtask

  task automatic test_backpressure;
    longint span;
    span = 300;
    set_geometry(500, 800, 24, 3);
    hold_reqs++;
    for (int i = 0; i < 40; i++) random_request(span);
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts and the long hold-off
  // --------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      rx_hold   <= RX_HOLD;
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && ($urandom % 6 == 0)) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor: compare each accepted response with the oldest expected
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    alloc_rsp_t exp_rsp;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response blk=%0d st=%0d cnt=%0d",
                 $time, res_blk, res_st, res_cnt);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (res_blk !== exp_rsp.blk) begin
          errors++;
          $display("%0t: result_block expected %0d actual %0d", $time, exp_rsp.blk, res_blk);
        end
        if (res_st !== exp_rsp.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_rsp.st, res_st);
        end
        if (res_cnt !== exp_rsp.cnt) begin
          errors++;
          $display("%0t: free_count expected %0d actual %0d", $time, exp_rsp.cnt, res_cnt);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WDOG_MAX) begin
      $display("bitmap_block_allocator_locality_core: mismatch");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    for (int i = 0; i < MAP_N; i++) free_bits[i] = 1'b0;
    free_cnt   = 0;
    first_data = 0;
    fs_blocks  = FS_SIZE_RST;
    cyl_blocks = DEF_CYL;
    rot_gap    = DEF_SPACE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_locality();
    test_counter_floor();
    test_extremes();
    test_backpressure();
    for (int p = 0; p < 5; p++) test_random(250);
    // last stretch without idling on either side
    idle_en = 1'b0;
    test_random(150);
    if (errors == 0) begin
      $display("bitmap_block_allocator_locality_core: match");
    end else begin
      $display("bitmap_block_allocator_locality_core: mismatch");
    end
    $finish;
  end

endmodule

@@ bitmap_block_allocator_locality_core.f @@
hdl/bba_pkg.sv
hdl/bba_map_ram.sv
hdl/bba_div.sv
hdl/bitmap_block_allocator_locality_core.sv
tb/tb.sv
